FILE: hdl/crcfc_pkg.sv
// shared types, codes and the crc-8 step for the frame receive checker
package crcfc_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned MinFrame = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 4'd0,
    CFG_HEADER_SECOND = 4'd1,
    CFG_OWN_ADDRESS   = 4'd2,
    CFG_TYPE_DATA     = 4'd3,
    CFG_TYPE_COMMAND  = 4'd4,
    CFG_CODE_CONTROL  = 4'd5,
    CFG_CODE_QUERY    = 4'd6,
    CFG_CODE_RESET    = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_HEADER  = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_CRC     = 3'd4,
    ST_ADDRESS = 3'd5,
    ST_TYPE    = 3'd6,
    ST_CODE    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CMD_CONTROL = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESET   = 2'd2
  } command_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] own_address;
    logic [7:0] type_data_value;
    logic [7:0] type_command_value;
    logic [7:0] code_control;
    logic [7:0] code_query;
    logic [7:0] code_reset;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      byte_count;
    logic [7:0]      crc_acc;
    logic [7:0]      length_byte;
    logic            header_good;
    logic [2:0][7:0] field_bytes;
    logic [2:0][7:0] arg_bytes;
    logic [7:0]      stored_crc;
  } frame_t;

  typedef struct packed {
    status_t    status;
    command_t   command;
    logic [7:0] frame_len;
    logic [7:0] switch_byte;
    logic [7:0] gear_byte;
    logic [7:0] level_byte;
  } result_t;

  // reflected polynomial 0x31, one byte per call
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ 8'h8C) : (v >> 1);
    end
    return v;
  endfunction

endpackage

FILE: hdl/crcfc_step.sv
// per-byte frame state update and end-of-frame verdict
module crcfc_step (
  input  crcfc_pkg::frame_t  frame,
  input  crcfc_pkg::cfg_t    cfg,
  input  logic [7:0]         byte_value,
  input  logic               last_byte,
  output crcfc_pkg::frame_t  frame_nxt,
  output crcfc_pkg::result_t result
);
  import crcfc_pkg::*;

  frame_t     upd;
  logic [7:0] idx;
  status_t    status;
  command_t   command;

  assign idx = frame.byte_count;

  always_comb begin
    upd = frame;
    if (idx != 8'hFF) begin
      if (idx == 8'd0) begin
        upd.header_good = (byte_value == cfg.header_first);
      end else if (idx == 8'd1) begin
        upd.header_good = frame.header_good && (byte_value == cfg.header_second);
      end else if (idx == 8'd2) begin
        upd.length_byte = byte_value;
      end else if (idx == 8'd3) begin
        upd.field_bytes[0] = byte_value;
      end else if (idx == 8'd4) begin
        upd.field_bytes[1] = byte_value;
      end else if (idx == 8'd5) begin
        upd.field_bytes[2] = byte_value;
      end else if (idx == 8'd6) begin
        upd.arg_bytes[0] = byte_value;
      end else if (idx == 8'd7) begin
        upd.arg_bytes[1] = byte_value;
      end else if (idx == 8'd8) begin
        upd.arg_bytes[2] = byte_value;
      end
      if (idx >= 8'd2 && ({1'b0, idx} + 9'd2) <= {1'b0, upd.length_byte}) begin
        upd.crc_acc = crc8_step(frame.crc_acc, byte_value);
      end
      if (idx >= 8'd2 && ({1'b0, idx} + 9'd1) == {1'b0, upd.length_byte}) begin
        upd.stored_crc = byte_value;
      end
      upd.byte_count = idx + 8'd1;
    end
  end

  always_comb begin
    status  = ST_OK;
    command = CMD_CONTROL;
    if (upd.byte_count < 8'(MinFrame)) begin
      status = ST_SHORT;
    end else if (!upd.header_good) begin
      status = ST_HEADER;
    end else if (upd.length_byte > upd.byte_count || upd.length_byte < 8'(MinFrame)) begin
      status = ST_LENGTH;
    end else if (upd.crc_acc != upd.stored_crc) begin
      status = ST_CRC;
    end else if (upd.field_bytes[0] != cfg.own_address) begin
      status = ST_ADDRESS;
    end else if (upd.field_bytes[1] != cfg.type_data_value &&
                 upd.field_bytes[1] != cfg.type_command_value) begin
      status = ST_TYPE;
    end else if (upd.field_bytes[2] == cfg.code_control) begin
      command = CMD_CONTROL;
    end else if (upd.field_bytes[2] == cfg.code_query) begin
      command = CMD_QUERY;
    end else if (upd.field_bytes[2] == cfg.code_reset) begin
      command = CMD_RESET;
    end else begin
      status = ST_CODE;
    end
  end

  always_comb begin
    result.status      = status;
    result.command     = (status == ST_OK) ? command : CMD_CONTROL;
    result.frame_len   = upd.length_byte;
    result.switch_byte = (status == ST_OK) ? upd.arg_bytes[0] : 8'd0;
    result.gear_byte   = (status == ST_OK) ? upd.arg_bytes[1] : 8'd0;
    result.level_byte  = (status == ST_OK) ? upd.arg_bytes[2] : 8'd0;
  end

  assign frame_nxt = last_byte ? '0 : upd;

endmodule

FILE: hdl/crc8_frame_receive_checker_unit.sv
// top level of the crc-8 framed command receive checker
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   in_      | sink      | tdata: byte_value; tlast: last_byte
//   out_     | source    | tdata: status, command, length, bytes 6..8
//   cfg_     | sink      | index + data, one 8-bit register per write
//
// one byte per cycle enters the input register, except while a last byte
// waits there; from that register the byte updates the frame state and,
// if last, loads the result register, whose valid flag drives out_tvalid.
// a last byte waits in the input register only while the result register
// is full and not taken; other bytes never stall.
// rst_n clears the frame state and both valid flags; config gets defaults.
module crc8_frame_receive_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] byte_value
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [4:3] command, [12:5] frame_len, [20:13] switch_byte,
  // [28:21] gear_byte, [36:29] level_byte, [39:37] zero
  output logic [39:0]                         out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crcfc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [7:0]                          cfg_data
);
  import crcfc_pkg::*;

  cfg_t       cfg_r;
  frame_t     frame_r;
  frame_t     frame_nxt;
  result_t    result;
  result_t    out_r;
  logic       out_valid_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_free;
  logic       advance;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first       <= 8'hA5;
      cfg_r.header_second      <= 8'hA5;
      cfg_r.own_address        <= 8'hB1;
      cfg_r.type_data_value    <= 8'h00;
      cfg_r.type_command_value <= 8'h80;
      cfg_r.code_control       <= 8'h01;
      cfg_r.code_query         <= 8'h02;
      cfg_r.code_reset         <= 8'h7D;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEADER_FIRST:  cfg_r.header_first       <= cfg_data;
        CFG_HEADER_SECOND: cfg_r.header_second      <= cfg_data;
        CFG_OWN_ADDRESS:   cfg_r.own_address        <= cfg_data;
        CFG_TYPE_DATA:     cfg_r.type_data_value    <= cfg_data;
        CFG_TYPE_COMMAND:  cfg_r.type_command_value <= cfg_data;
        CFG_CODE_CONTROL:  cfg_r.code_control       <= cfg_data;
        CFG_CODE_QUERY:    cfg_r.code_query         <= cfg_data;
        CFG_CODE_RESET:    cfg_r.code_reset         <= cfg_data;
        default: ;
      endcase
    end
  end

  crcfc_step u_step (
    .frame      (frame_r),
    .cfg        (cfg_r),
    .byte_value (s1_byte_r),
    .last_byte  (s1_last_r),
    .frame_nxt  (frame_nxt),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (advance) begin
      frame_r <= frame_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.level_byte, out_r.gear_byte, out_r.switch_byte,
                       out_r.frame_len, out_r.command, out_r.status};

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |->
      (out_r.command == CMD_CONTROL && out_r.switch_byte == 8'd0 &&
       out_r.gear_byte == 8'd0 && out_r.level_byte == 8'd0))
    else $error("failed frame carries command payload");

  a_ok_min_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_OK) |-> out_r.frame_len >= 8'(MinFrame))
    else $error("good frame shorter than minimum");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> (frame_r == '0))
    else $error("frame state not cleared after last item");

  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && !out_free) |-> (!in_tready && !advance))
    else $error("last item passed a full result register");

endmodule

FILE: sim/tb_top.sv
// testbench for the crc-8 frame receive checker: directed and random buffers checked by a predictor
module tb_top;
  import crcfc_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum int {
    FLAW_NONE, FLAW_SHORT, FLAW_HEADER1, FLAW_HEADER2, FLAW_LEN_SMALL, FLAW_LEN_BIG,
    FLAW_CRC, FLAW_ADDR, FLAW_TYPE, FLAW_CODE
  } flaw_t;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [39:0]          out_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [7:0]           cfg_data;

  // predictor copy of the registers and the frame state
  cfg_t       active_regs;
  logic [7:0] rx_count;
  logic [7:0] rx_crc;
  logic [7:0] rx_len;
  logic       rx_hdr_ok;
  logic [7:0] rx_fields [3];
  logic [7:0] rx_args [3];
  logic [7:0] rx_crc_byte;

  result_t    pending_verdicts [$];
  result_t    want;
  logic [7:0] frame_bytes [$];
  int         mismatch_count;
  int         sent_count;
  int         hold_left;
  int         cycle_count;
  bit         steady;

  crc8_frame_receive_checker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    r = acc ^ d;
    repeat (8) r = {1'b0, r[7:1]} ^ (r[0] ? 8'h8C : 8'h00);
    return r;
  endfunction

  function automatic cfg_t default_regs();
    cfg_t r;
    r.header_first       = 8'hA5;
    r.header_second      = 8'hA5;
    r.own_address        = 8'hB1;
    r.type_data_value    = 8'h00;
    r.type_command_value = 8'h80;
    r.code_control       = 8'h01;
    r.code_query         = 8'h02;
    r.code_reset         = 8'h7D;
    return r;
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 94) return $urandom_range(4, 8);
    else return $urandom_range(12, 40);
  endfunction

  task automatic clear_rx();
    rx_count = '0;
    rx_crc = '0;
    rx_len = '0;
    rx_hdr_ok = 1'b0;
    rx_crc_byte = '0;
    for (int k = 0; k < 3; k++) begin
      rx_fields[k] = '0;
      rx_args[k] = '0;
    end
  endtask

  task automatic track_rx_byte(input logic [7:0] b, input logic last);
    int      idx;
    result_t res;
    idx = rx_count;
    if (idx < 255) begin
      if (idx == 0) rx_hdr_ok = (b == active_regs.header_first);
      else if (idx == 1) rx_hdr_ok = rx_hdr_ok && (b == active_regs.header_second);
      else if (idx == 2) rx_len = b;
      else if (idx <= 5) rx_fields[idx-3] = b;
      else if (idx <= 8) rx_args[idx-6] = b;
      if (idx >= 2 && idx + 2 <= int'(rx_len)) rx_crc = crc_fold(rx_crc, b);
      if (idx >= 2 && idx + 1 == int'(rx_len)) rx_crc_byte = b;
      rx_count = 8'(idx + 1);
    end
    if (last) begin
      res = '0;
      res.status = ST_OK;
      res.command = CMD_CONTROL;
      res.frame_len = rx_len;
      if (rx_count < MinFrame) res.status = ST_SHORT;
      else if (!rx_hdr_ok) res.status = ST_HEADER;
      else if (rx_len > rx_count || rx_len < MinFrame) res.status = ST_LENGTH;
      else if (rx_crc != rx_crc_byte) res.status = ST_CRC;
      else if (rx_fields[0] != active_regs.own_address) res.status = ST_ADDRESS;
      else if (rx_fields[1] != active_regs.type_data_value &&
               rx_fields[1] != active_regs.type_command_value) res.status = ST_TYPE;
      else if (rx_fields[2] == active_regs.code_control) res.command = CMD_CONTROL;
      else if (rx_fields[2] == active_regs.code_query) res.command = CMD_QUERY;
      else if (rx_fields[2] == active_regs.code_reset) res.command = CMD_RESET;
      else res.status = ST_CODE;
      if (res.status == ST_OK) begin
        res.switch_byte = rx_args[0];
        res.gear_byte = rx_args[1];
        res.level_byte = rx_args[2];
      end else begin
        res.command = CMD_CONTROL;
      end
      pending_verdicts.push_back(res);
      clear_rx();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) track_rx_byte(in_tdata, in_tlast);
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  active_regs.header_first = cfg_data;
        CFG_HEADER_SECOND: active_regs.header_second = cfg_data;
        CFG_OWN_ADDRESS:   active_regs.own_address = cfg_data;
        CFG_TYPE_DATA:     active_regs.type_data_value = cfg_data;
        CFG_TYPE_COMMAND:  active_regs.type_command_value = cfg_data;
        CFG_CODE_CONTROL:  active_regs.code_control = cfg_data;
        CFG_CODE_QUERY:    active_regs.code_query = cfg_data;
        CFG_CODE_RESET:    active_regs.code_reset = cfg_data;
        default: ;
      endcase
    end
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        note_mismatch($sformatf("result 0x%h with none pending", out_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata[2:0] !== want.status)
          note_mismatch($sformatf("status got %0d expected %0d", out_tdata[2:0], want.status));
        if (out_tdata[4:3] !== want.command)
          note_mismatch($sformatf("command got %0d expected %0d", out_tdata[4:3], want.command));
        if (out_tdata[12:5] !== want.frame_len)
          note_mismatch($sformatf("frame_len got %0d expected %0d", out_tdata[12:5],
                                  want.frame_len));
        if (out_tdata[20:13] !== want.switch_byte)
          note_mismatch($sformatf("switch_byte got %0d expected %0d", out_tdata[20:13],
                                  want.switch_byte));
        if (out_tdata[28:21] !== want.gear_byte)
          note_mismatch($sformatf("gear_byte got %0d expected %0d", out_tdata[28:21],
                                  want.gear_byte));
        if (out_tdata[36:29] !== want.level_byte)
          note_mismatch($sformatf("level_byte got %0d expected %0d", out_tdata[36:29],
                                  want.level_byte));
      end
    end
  end

  // receiver side stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      hold_left = pick_pause() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 60) ? 0 : pick_pause();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= b;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_frame_bytes();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 19) == 0));
  endtask

  // extra: tail bytes past the frame, or the whole buffer size for a short buffer
  task automatic build_frame(input flaw_t flaw, input int len, input int extra,
                             input int type_sel, input int cmd_sel, input fill_t fill);
    int         total;
    logic [7:0] acc;
    logic [7:0] v;
    total = len + extra;
    frame_bytes.delete();
    for (int i = 0; i < total; i++) begin
      case (fill)
        FILL_ZERO: v = 8'h00;
        FILL_ONES: v = 8'hFF;
        default:   v = 8'($urandom);
      endcase
      frame_bytes.push_back(v);
    end
    frame_bytes[0] = active_regs.header_first;
    frame_bytes[1] = active_regs.header_second;
    frame_bytes[2] = 8'(len);
    frame_bytes[3] = active_regs.own_address;
    frame_bytes[4] = type_sel ? active_regs.type_command_value : active_regs.type_data_value;
    frame_bytes[5] = (cmd_sel == 0) ? active_regs.code_control :
                     (cmd_sel == 1) ? active_regs.code_query : active_regs.code_reset;
    case (flaw)
      FLAW_HEADER1:   frame_bytes[0] ^= 8'($urandom_range(1, 255));
      FLAW_HEADER2:   frame_bytes[1] ^= 8'($urandom_range(1, 255));
      FLAW_ADDR:      frame_bytes[3] ^= 8'($urandom_range(1, 255));
      FLAW_LEN_SMALL: frame_bytes[2] = 8'($urandom_range(0, MinFrame - 1));
      FLAW_LEN_BIG:   frame_bytes[2] = 8'($urandom_range(total + 1, 255));
      FLAW_TYPE: begin
        do v = 8'($urandom);
        while (v == active_regs.type_data_value || v == active_regs.type_command_value);
        frame_bytes[4] = v;
      end
      FLAW_CODE: begin
        do v = 8'($urandom);
        while (v == active_regs.code_control || v == active_regs.code_query ||
               v == active_regs.code_reset);
        frame_bytes[5] = v;
      end
      default: ;
    endcase
    acc = 8'h00;
    for (int i = 2; i <= len - 2; i++) acc = crc_fold(acc, frame_bytes[i]);
    frame_bytes[len-1] = acc;
    if (flaw == FLAW_CRC) frame_bytes[len-1] ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_SHORT) begin
      while (frame_bytes.size() > extra) void'(frame_bytes.pop_back());
    end
  endtask

  task automatic frame(input flaw_t flaw, input int len, input int extra,
                       input int type_sel, input int cmd_sel, input fill_t fill);
    build_frame(flaw, len, extra, type_sel, cmd_sel, fill);
    send_frame_bytes();
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [7:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_load(input cfg_t r);
    cfg_put(CFG_HEADER_FIRST, r.header_first);
    cfg_put(CFG_HEADER_SECOND, r.header_second);
    cfg_put(CFG_OWN_ADDRESS, r.own_address);
    cfg_put(CFG_TYPE_DATA, r.type_data_value);
    cfg_put(CFG_TYPE_COMMAND, r.type_command_value);
    cfg_put(CFG_CODE_CONTROL, r.code_control);
    cfg_put(CFG_CODE_QUERY, r.code_query);
    cfg_put(CFG_CODE_RESET, r.code_reset);
    // index past the register list, must be ignored
    cfg_put(CfgIdxW'(CFG_CODE_RESET) + CfgIdxW'($urandom_range(1, 8)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_commands();
    frame(FLAW_NONE, 7, 0, 0, 0, FILL_RANDOM);
    frame(FLAW_NONE, 9, 2, 1, 1, FILL_ONES);
    frame(FLAW_NONE, 12, 0, 0, 2, FILL_ZERO);
    frame(FLAW_NONE, 8, 1, 1, 0, FILL_RANDOM);
  endtask

  task automatic test_error_status();
    send_byte(8'hFF, 1'b1);
    frame(FLAW_SHORT, 7, 6, 0, 0, FILL_RANDOM);
    frame(FLAW_HEADER1, 8, 0, 0, 0, FILL_RANDOM);
    frame(FLAW_HEADER2, 8, 0, 1, 1, FILL_RANDOM);
    frame(FLAW_LEN_SMALL, 9, 0, 0, 0, FILL_RANDOM);
    frame(FLAW_LEN_BIG, 9, 1, 0, 0, FILL_RANDOM);
    frame(FLAW_CRC, 10, 0, 1, 2, FILL_RANDOM);
    frame(FLAW_ADDR, 9, 0, 0, 1, FILL_RANDOM);
    frame(FLAW_TYPE, 9, 0, 0, 0, FILL_RANDOM);
    frame(FLAW_CODE, 9, 0, 1, 0, FILL_RANDOM);
  endtask

  task automatic test_long_buffers();
    // byte counter saturates, bytes past the limit are ignored
    frame(FLAW_NONE, 255, 5, 1, 1, FILL_RANDOM);
    frame(FLAW_CRC, 40, 3, 0, 2, FILL_RANDOM);
  endtask

  task automatic test_register_extremes();
    cfg_t r;
    wait_idle();
    r = '0;
    cfg_load(r);
    frame(FLAW_NONE, 9, 0, 0, 2, FILL_ZERO);
    frame(FLAW_TYPE, 8, 0, 0, 0, FILL_RANDOM);
    frame(FLAW_CODE, 8, 0, 0, 0, FILL_RANDOM);
    frame(FLAW_HEADER1, 8, 0, 0, 0, FILL_RANDOM);
    wait_idle();
    r = '1;
    cfg_load(r);
    frame(FLAW_NONE, 9, 0, 1, 2, FILL_ONES);
    frame(FLAW_ADDR, 9, 0, 1, 0, FILL_RANDOM);
    frame(FLAW_CRC, 9, 0, 0, 1, FILL_RANDOM);
    wait_idle();
    // query and reset codes equal: query wins
    r = default_regs();
    r.code_query = 8'h40;
    r.code_reset = 8'h40;
    cfg_load(r);
    frame(FLAW_NONE, 10, 0, 0, 2, FILL_RANDOM);
    wait_idle();
    // control and query codes equal: control wins
    r.code_control = 8'h55;
    r.code_query = 8'h55;
    r.code_reset = 8'h56;
    cfg_load(r);
    frame(FLAW_NONE, 10, 0, 1, 1, FILL_RANDOM);
    frame(FLAW_NONE, 10, 0, 1, 2, FILL_RANDOM);
    wait_idle();
    cfg_load(default_regs());
  endtask

  function automatic logic [7:0] pick_reg_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    else if (r < 30) return 8'hFF;
    else return 8'($urandom);
  endfunction

  task automatic random_buffer();
    int r;
    int len;
    int extra;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(7, 16);
    extra = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
    if (r < 55) begin
      frame(FLAW_NONE, len, extra, $urandom_range(0, 1), $urandom_range(0, 2), FILL_RANDOM);
    end else if (r < 85) begin
      build_frame(flaw_t'($urandom_range(FLAW_SHORT, FLAW_CODE)), len, extra,
                  $urandom_range(0, 1), $urandom_range(0, 2), FILL_RANDOM);
      send_frame_bytes();
    end else begin
      send_noise();
    end
  endtask

  task automatic test_random_traffic();
    cfg_t r;
    int   stop_at;
    int   phase_end;
    stop_at = sent_count + 230;
    while (sent_count < stop_at) begin
      wait_idle();
      if ($urandom_range(0, 99) < 70) begin
        r.header_first = pick_reg_value();
        r.header_second = pick_reg_value();
        r.own_address = pick_reg_value();
        r.type_data_value = pick_reg_value();
        r.type_command_value = pick_reg_value();
        r.code_control = pick_reg_value();
        r.code_query = pick_reg_value();
        r.code_reset = pick_reg_value();
        if ($urandom_range(0, 9) == 0) begin
          r.code_query = r.code_control;
          r.code_reset = r.code_control;
        end
        cfg_load(r);
      end
      steady = ($urandom_range(0, 3) == 0);
      phase_end = sent_count + $urandom_range(50, 100);
      while (sent_count < phase_end) random_buffer();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    hold_left = 0;
    mismatch_count = 0;
    sent_count = 0;
    cycle_count = 0;
    active_regs = default_regs();
    clear_rx();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_commands();
    test_error_status();
    test_long_buffers();
    test_register_extremes();
    test_random_traffic();

    wait_idle();
    repeat (20) @(negedge clk);
    if (pending_verdicts.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/crcfc_pkg.sv
hdl/crcfc_step.sv
hdl/crc8_frame_receive_checker_unit.sv
sim/tb_top.sv
